// ===== hw/rtl/decaying_dual_tone_chime_defines.svh =====
// ============================================================================
// decaying_dual_tone_chime_defines.svh
// Assertion macros shared by the chime generator RTL.
// ============================================================================
`ifndef DECAYING_DUAL_TONE_CHIME_DEFINES_SVH
`define DECAYING_DUAL_TONE_CHIME_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dtc_pkg.sv =====
// ============================================================================
// dtc_pkg
// Shared types and constants of the decaying dual-tone chime generator.
// ============================================================================
package dtc_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_TONE_ONE_STEP = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TONE_TWO_STEP = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_FACTOR  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_GAIN   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_LEVEL    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHIME_LENGTH  = 3'd5;

  // Register reset values.
  localparam logic [31:0] RST_TONE_ONE_STEP = 32'd171409139;
  localparam logic [31:0] RST_TONE_TWO_STEP = 32'd215961693;
  localparam logic [23:0] RST_DECAY_FACTOR  = 24'd16772271;
  localparam logic [15:0] RST_OUTPUT_GAIN   = 16'd20972;
  localparam logic [14:0] RST_CLIP_LEVEL    = 15'd32111;
  localparam logic [15:0] RST_CHIME_LENGTH  = 16'd6615;

  // Configuration register file contents.
  typedef struct packed {
    logic [31:0] tone_one_step;
    logic [31:0] tone_two_step;
    logic [23:0] decay_factor;
    logic [15:0] output_gain;
    logic [14:0] clip_level;
    logic [15:0] chime_length;
  } cfg_t;

  // Datapath arithmetic widths and constants.
  localparam int WORK_BITS  = 17;   // x, x squared, polynomial terms, magnitudes
  localparam int SUM_BITS   = 19;   // signed sum of the two tones
  localparam int MULB_BITS  = 24;   // second multiplier operand
  localparam int SINE_SHIFT = 16;
  localparam int GAIN_SHIFT = 17;
  localparam int DECAY_SHIFT = 24;
  localparam logic [WORK_BITS-1:0] SIN_C3   = 17'd4926;
  localparam logic [WORK_BITS-1:0] SIN_C2   = 17'd42334;
  localparam logic [WORK_BITS-1:0] SIN_C1   = 17'd102944;
  localparam logic [WORK_BITS-1:0] SIN_FULL = 17'd32767;

  // Datapath operation codes, one per multiplication.
  localparam int OP_BITS = 4;
  localparam logic [OP_BITS-1:0] OP_X2_A    = 4'd0;
  localparam logic [OP_BITS-1:0] OP_T1_A    = 4'd1;
  localparam logic [OP_BITS-1:0] OP_T2_A    = 4'd2;
  localparam logic [OP_BITS-1:0] OP_Y_A     = 4'd3;
  localparam logic [OP_BITS-1:0] OP_MAG_A   = 4'd4;
  localparam logic [OP_BITS-1:0] OP_X2_B    = 4'd5;
  localparam logic [OP_BITS-1:0] OP_T1_B    = 4'd6;
  localparam logic [OP_BITS-1:0] OP_T2_B    = 4'd7;
  localparam logic [OP_BITS-1:0] OP_Y_B     = 4'd8;
  localparam logic [OP_BITS-1:0] OP_MAG_B   = 4'd9;
  localparam logic [OP_BITS-1:0] OP_ENV     = 4'd10;
  localparam logic [OP_BITS-1:0] OP_GAIN    = 4'd11;
  localparam logic [OP_BITS-1:0] OP_DECAY   = 4'd12;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               take;      // tick word accepted, apply start request
    logic               mul;       // register the product of the selected operands
    logic               wb;        // write the registered product back
    logic [OP_BITS-1:0] op;        // operation being worked on
    logic               load_out;  // load the output word and advance the chime
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic playing;
  } status_t;

endpackage

// ===== hw/rtl/dtc_if.sv =====
// ============================================================================
// dtc_if
// Valid/ready channel interfaces of the chime generator.
// ============================================================================

// Sample tick channel.
interface dtc_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

// Audio sample channel.
interface dtc_audio_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample;
  logic              last;
  logic              active;
  modport source (output valid, output sample, output last, output active, input ready);
  modport sink (input valid, input sample, input last, input active, output ready);
endinterface

// Configuration write channel.
interface dtc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dtc_pkg::CFG_INDEX_BITS-1:0] index;
  logic [dtc_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/dtc_cfg.sv =====
// ============================================================================
// dtc_cfg
// Configuration register file, written one register per word.
// ============================================================================
module dtc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_valid,
  output logic                                wr_ready,
  input  logic [dtc_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [dtc_pkg::CFG_DATA_BITS-1:0]  wr_data,
  output dtc_pkg::cfg_t                       regs
);

  // Writes are always taken.
  assign wr_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tone_one_step <= dtc_pkg::RST_TONE_ONE_STEP;
      regs.tone_two_step <= dtc_pkg::RST_TONE_TWO_STEP;
      regs.decay_factor  <= dtc_pkg::RST_DECAY_FACTOR;
      regs.output_gain   <= dtc_pkg::RST_OUTPUT_GAIN;
      regs.clip_level    <= dtc_pkg::RST_CLIP_LEVEL;
      regs.chime_length  <= dtc_pkg::RST_CHIME_LENGTH;
    end else if (wr_valid) begin
      case (wr_index)
        dtc_pkg::REG_TONE_ONE_STEP: regs.tone_one_step <= wr_data;
        dtc_pkg::REG_TONE_TWO_STEP: regs.tone_two_step <= wr_data;
        dtc_pkg::REG_DECAY_FACTOR:  regs.decay_factor  <= wr_data[23:0];
        dtc_pkg::REG_OUTPUT_GAIN:   regs.output_gain   <= wr_data[15:0];
        dtc_pkg::REG_CLIP_LEVEL:    regs.clip_level    <= wr_data[14:0];
        dtc_pkg::REG_CHIME_LENGTH:  regs.chime_length  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dtc_ctrl.sv =====
// ============================================================================
// dtc_ctrl
// Sequencer of the chime generator: walks the shared multiplier through
// the thirteen products of one sample and owns both handshakes.
// ============================================================================
module dtc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_valid,
  output logic             tick_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dtc_pkg::status_t status,
  output dtc_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_WB    = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [dtc_pkg::OP_BITS-1:0] op;
  logic [dtc_pkg::OP_BITS-1:0] op_next;
  logic                        out_free;

  assign tick_ready = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    op_next      = op;
    cmd.take     = 1'b0;
    cmd.mul      = 1'b0;
    cmd.wb       = 1'b0;
    cmd.op       = op;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (tick_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        op_next = dtc_pkg::OP_X2_A;
        if (status.playing) begin
          state_next = S_MUL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (op == dtc_pkg::OP_DECAY) begin
          state_next = S_OUT;
        end else begin
          op_next    = op + 1'b1;
          state_next = S_MUL;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, operation counter and output word flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= dtc_pkg::OP_X2_A;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/dtc_dp.sv =====
// ============================================================================
// dtc_dp
// Datapath of the chime generator: phase accumulators, envelope, sample
// counter, one shared multiplier and the output word register.
// ============================================================================
module dtc_dp #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int ENV_FRAC_BITS   = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  dtc_pkg::cmd_t      cmd,
  output dtc_pkg::status_t   status,
  input  logic               start_req,
  input  dtc_pkg::cfg_t      regs,
  output logic signed [15:0] sample,
  output logic               last,
  output logic               active
);

  localparam int WB  = dtc_pkg::WORK_BITS;
  localparam int SB  = dtc_pkg::SUM_BITS;
  localparam int QW  = SINE_TABLE_BITS - 2;
  localparam int AW  = ENV_FRAC_BITS + 1;
  localparam int BW  = dtc_pkg::MULB_BITS;
  localparam int PW  = AW + BW;
  localparam logic [AW-1:0] ENV_ONE = AW'(1) << ENV_FRAC_BITS;
  localparam logic [QW:0]   QUARTER = (QW + 1)'(1) << QW;

  // Chime state.
  logic [PHASE_BITS-1:0] phase_one;
  logic [PHASE_BITS-1:0] phase_two;
  logic [AW-1:0]         envelope;
  logic [15:0]           sample_index;
  logic                  playing;

  // Working registers.
  logic [PW-1:0]        prod;
  logic [WB-1:0]        wx2;
  logic [WB-1:0]        wt;
  logic [WB-1:0]        wm;
  logic signed [SB-1:0] sum;

  logic                  tone_b;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [QW:0]           q_mirror;
  logic [WB-1:0]         x;
  logic                  neg;
  logic [WB-1:0]         mag;
  logic signed [SB-1:0]  mag_signed;
  logic [SB-1:0]         abs_sum;
  logic [AW-1:0]         mul_a;
  logic [BW-1:0]         mul_b;
  logic [14:0]           clamped;
  logic [15:0]           mag16;
  logic                  last_now;

  assign status.playing = playing;

  // Sine argument of the tone being worked on: quadrant fold and scale to Q16.
  assign tone_b    = (cmd.op >= dtc_pkg::OP_X2_B) && (cmd.op <= dtc_pkg::OP_MAG_B);
  assign phase_cur = tone_b ? phase_two : phase_one;
  assign idx       = phase_cur[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign q_mirror  = idx[QW] ? (QUARTER - {1'b0, idx[QW-1:0]}) : {1'b0, idx[QW-1:0]};
  assign x         = {q_mirror, {(16 - QW){1'b0}}};
  assign neg       = idx[SINE_TABLE_BITS-1];

  // Tone magnitude from the registered product, signed by the quadrant.
  assign mag        = prod[dtc_pkg::SINE_SHIFT +: WB];
  assign mag_signed = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign abs_sum    = sum[SB-1] ? SB'(-sum) : SB'(sum);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      dtc_pkg::OP_X2_A, dtc_pkg::OP_X2_B: begin
        mul_a = AW'(x);
        mul_b = BW'(x);
      end
      dtc_pkg::OP_T1_A, dtc_pkg::OP_T1_B: begin
        mul_a = AW'(wx2);
        mul_b = BW'(dtc_pkg::SIN_C3);
      end
      dtc_pkg::OP_T2_A, dtc_pkg::OP_T2_B: begin
        mul_a = AW'(wx2);
        mul_b = BW'(wt);
      end
      dtc_pkg::OP_Y_A, dtc_pkg::OP_Y_B: begin
        mul_a = AW'(x);
        mul_b = BW'(wt);
      end
      dtc_pkg::OP_MAG_A, dtc_pkg::OP_MAG_B: begin
        mul_a = AW'(wt);
        mul_b = BW'(dtc_pkg::SIN_FULL);
      end
      dtc_pkg::OP_ENV: begin
        mul_a = envelope;
        mul_b = BW'(abs_sum[WB-1:0]);
      end
      dtc_pkg::OP_GAIN: begin
        mul_a = AW'(wm);
        mul_b = BW'(regs.output_gain);
      end
      dtc_pkg::OP_DECAY: begin
        mul_a = envelope;
        mul_b = regs.decay_factor;
      end
      default: ;
    endcase
  end

  // Product register and write-back into the working registers.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.wb) begin
      case (cmd.op)
        dtc_pkg::OP_X2_A, dtc_pkg::OP_X2_B: wx2 <= prod[dtc_pkg::SINE_SHIFT +: WB];
        dtc_pkg::OP_T1_A, dtc_pkg::OP_T1_B: wt <= dtc_pkg::SIN_C2 - prod[dtc_pkg::SINE_SHIFT +: WB];
        dtc_pkg::OP_T2_A, dtc_pkg::OP_T2_B: wt <= dtc_pkg::SIN_C1 - prod[dtc_pkg::SINE_SHIFT +: WB];
        dtc_pkg::OP_Y_A, dtc_pkg::OP_Y_B:   wt <= prod[dtc_pkg::SINE_SHIFT +: WB];
        dtc_pkg::OP_MAG_A:                  sum <= mag_signed;
        dtc_pkg::OP_MAG_B:                  sum <= sum + mag_signed;
        dtc_pkg::OP_ENV:                    wm <= prod[ENV_FRAC_BITS +: WB];
        dtc_pkg::OP_GAIN:                   wm <= prod[dtc_pkg::GAIN_SHIFT +: WB];
        default: ;
      endcase
    end
  end

  // Clamp to the clip level and restore the sign of the tone sum.
  assign clamped  = (wm > WB'(regs.clip_level)) ? regs.clip_level : wm[14:0];
  assign mag16    = {1'b0, clamped};
  assign last_now = ({1'b0, sample_index} + 17'd1) >= {1'b0, regs.chime_length};

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (playing) begin
        sample <= sum[SB-1] ? $signed(~mag16 + 16'd1) : $signed(mag16);
      end else begin
        sample <= '0;
      end
      last   <= playing && last_now;
      active <= playing;
    end
  end

  // Chime state: restart on a start request, advance after each played sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_one    <= '0;
      phase_two    <= '0;
      envelope     <= ENV_ONE;
      sample_index <= '0;
      playing      <= 1'b0;
    end else begin
      if (cmd.take && start_req) begin
        phase_one    <= '0;
        phase_two    <= '0;
        envelope     <= ENV_ONE;
        sample_index <= '0;
        playing      <= 1'b1;
      end
      if (cmd.wb && (cmd.op == dtc_pkg::OP_DECAY)) begin
        envelope <= prod[dtc_pkg::DECAY_SHIFT +: AW];
      end
      if (cmd.load_out && playing) begin
        phase_one    <= phase_one + regs.tone_one_step[PHASE_BITS-1:0];
        phase_two    <= phase_two + regs.tone_two_step[PHASE_BITS-1:0];
        sample_index <= sample_index + 16'd1;
        if (last_now) begin
          playing <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/decaying_dual_tone_chime.sv =====
// ============================================================================
// decaying_dual_tone_chime
// Dual-tone chime generator with exponential decay, one PCM word per tick.
// ============================================================================
//
//   Channel  Role    Word contents
//   -------  ------  ----------------------------------------------------
//   tick     sink    start_req: restart the chime, else plain sample tick
//   audio    source  sample (signed 16 bit), last, active
//   cfg      sink    index (3 bit register number), data (32 bit value)
//
// A playing tick goes from acceptance to a loaded output word in one accept
// step, one check, 13 products of a multiply and a write-back step each on
// the single shared multiplier, and one output load. A silent tick skips them.
// Synchronous reset returns the registers to their defaults and idles the chime.
// The output register holds a word until taken; the next tick is accepted
// meanwhile and its word waits in the controller until the register frees.
//
module decaying_dual_tone_chime #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int ENV_FRAC_BITS   = 24
) (
  input logic         clk,
  input logic         rst,
  dtc_tick_if.sink    tick,
  dtc_audio_if.source audio,
  dtc_cfg_if.sink     cfg
);

  `include "decaying_dual_tone_chime_defines.svh"

  dtc_pkg::cfg_t    regs;
  dtc_pkg::cmd_t    cmd;
  dtc_pkg::status_t status;

  // Configuration registers.
  dtc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (regs)
  );

  // Sequencer.
  dtc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .out_valid  (audio.valid),
    .out_ready  (audio.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Arithmetic and chime state.
  dtc_dp #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .ENV_FRAC_BITS   (ENV_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .start_req (tick.start_req),
    .regs      (regs),
    .sample    (audio.sample),
    .last      (audio.last),
    .active    (audio.active)
  );

  // A tick is worked on alone: no second word is taken in the next cycle.
  `DTC_ASSERT_NEXT(a_one_tick, tick.valid && tick.ready, !tick.ready, "tick taken twice")

  // A new word is never loaded over one that is still waiting.
  `DTC_ASSERT_SAME(a_no_overwrite, cmd.load_out, !audio.valid || audio.ready, "word overwritten")

  // A silent word carries no sample and no end flag.
  `DTC_ASSERT_SAME(a_silent, audio.valid && !audio.active, (audio.sample == 16'sd0) && !audio.last, "silent word not zero")

  // A played sample stays within the clip level.
  `DTC_ASSERT_SAME(a_clip, audio.valid && audio.active, ($signed(audio.sample) <= $signed({1'b0, regs.clip_level})) && ($signed(audio.sample) >= -$signed({1'b0, regs.clip_level})), "sample beyond clip level")

endmodule
